// ===== hw/rtl/swls_pkg.sv =====
// Shared types, codes and reset values for the stopwatch with LED scanner.
`timescale 1ns / 1ps

package swls_pkg;

	typedef struct packed {
		logic btn_slower;
		logic btn_faster;
		logic btn_clear;
		logic btn_halt;
		logic btn_start;
	} tick_t;

	typedef struct packed {
		logic [7:0] led_pattern;
		logic [9:0] millis;
		logic [5:0] seconds;
		logic [5:0] minutes;
		logic [7:0] hours;
		logic [1:0] run_mode;
	} result_t;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 10;

	localparam logic [CFG_INDEX_W-1:0] CFG_TICK_WHOLE_MS  = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TICK_EXTRA_US  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_SPEED_STEP     = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_FLOOR   = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] CFG_PERIOD_CEILING = 3'd4;

	localparam logic [1:0] MODE_RUN   = 2'd0;
	localparam logic [1:0] MODE_HALT  = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	localparam logic [7:0] TICK_WHOLE_MS_RST  = 8'd8;
	localparam logic [9:0] TICK_EXTRA_US_RST  = 10'd192;
	localparam logic [7:0] SPEED_STEP_RST     = 8'd20;
	localparam logic [9:0] PERIOD_FLOOR_RST   = 10'd20;
	localparam logic [9:0] PERIOD_CEILING_RST = 10'd1000;
	localparam logic [9:0] SCAN_PERIOD_RST    = 10'd200;
	localparam logic [3:0] LEFT_NIBBLE_RST    = 4'b1000;
	localparam logic [3:0] RIGHT_NIBBLE_RST   = 4'b0001;

	localparam logic [3:0]  NIBBLE_FULL  = 4'b1111;
	localparam logic [3:0]  NIBBLE_EMPTY = 4'b0000;
	localparam logic [10:0] US_PER_MS    = 11'd1000;
	localparam logic [10:0] MS_PER_SEC   = 11'd1000;
	localparam logic [6:0]  SEC_PER_MIN  = 7'd60;
	localparam logic [6:0]  MIN_PER_HOUR = 7'd60;
	localparam logic [10:0] PERIOD_MAX   = 11'd1023;
	localparam logic [11:0] ACCUM_MAX    = 12'd2047;

endpackage

// ===== hw/rtl/stopwatch_with_led_scanner.sv =====
// Stopwatch with LED bar scanner: one tick request in, one result out.
// The result of a tick request is registered and presented in the cycle after it is taken.
// Throughput: one tick request per cycle; the single output register stalls input
// only while a result is held and the output side stalls.
// Reset: arst_n sets all state but the result data register to its power-up values
// and the config registers to their defaults; no result is pending after reset.
`timescale 1ns / 1ps

module stopwatch_with_led_scanner (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                tick_valid,
	output logic                                tick_stall,
	input  swls_pkg::tick_t                     tick,
	output logic                                result_valid,
	input  logic                                result_stall,
	output swls_pkg::result_t                   result,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [swls_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [swls_pkg::CFG_DATA_W-1:0]     cfg_data
);

	logic [7:0]  tick_whole_ms_q;
	logic [9:0]  tick_extra_us_q;
	logic [7:0]  speed_step_q;
	logic [9:0]  period_floor_q;
	logic [9:0]  period_ceiling_q;

	logic [9:0]  us_accum_q;
	logic [10:0] pattern_accum_q;
	logic [9:0]  scan_period_q;
	logic [3:0]  left_nibble_q;
	logic [3:0]  right_nibble_q;
	logic        emptying_q;
	logic [1:0]  mode_q;
	logic [9:0]  ms_count_q;
	logic [5:0]  sec_count_q;
	logic [5:0]  min_count_q;
	logic [7:0]  hour_count_q;

	logic              result_valid_q;
	swls_pkg::result_t result_q;

	logic        accept;
	logic [10:0] period_up;
	logic [9:0]  period_d;
	logic [1:0]  mode_d;
	logic [10:0] us_sum;
	logic        us_carry;
	logic [9:0]  us_d;
	logic [8:0]  elapsed;
	logic [11:0] pat_sum;
	logic [11:0] pat_sat;
	logic        pat_step;
	logic [10:0] pat_d;
	logic        empt_d;
	logic [3:0]  left_d;
	logic [3:0]  right_d;
	logic [10:0] ms_sum;
	logic        ms_wrap;
	logic [6:0]  sec_inc;
	logic        sec_wrap;
	logic [6:0]  min_inc;
	logic        min_wrap;
	logic [9:0]  ms_d;
	logic [5:0]  sec_d;
	logic [5:0]  min_d;
	logic [7:0]  hour_d;

	assign tick_stall   = result_valid_q & result_stall;
	assign accept       = tick_valid & ~tick_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;
	assign cfg_ready    = 1'b1;

	always_comb begin
		period_up = {1'b0, scan_period_q} + {3'b000, speed_step_q};
		period_d  = scan_period_q;
		if (tick.btn_slower && (scan_period_q < period_ceiling_q)) begin
			period_d = (period_up > swls_pkg::PERIOD_MAX) ? swls_pkg::PERIOD_MAX[9:0]
				: period_up[9:0];
		end else if (tick.btn_faster && (scan_period_q > period_floor_q)) begin
			period_d = (scan_period_q > {2'b00, speed_step_q})
				? scan_period_q - {2'b00, speed_step_q} : 10'd0;
		end

		mode_d = mode_q;
		if (tick.btn_clear) begin
			mode_d = swls_pkg::MODE_CLEAR;
		end else if (tick.btn_halt) begin
			mode_d = swls_pkg::MODE_HALT;
		end else if (tick.btn_start) begin
			mode_d = swls_pkg::MODE_RUN;
		end

		us_sum   = {1'b0, us_accum_q} + {1'b0, tick_extra_us_q};
		us_carry = us_sum >= swls_pkg::US_PER_MS;
		us_d     = us_carry ? 10'd0 : us_sum[9:0];
		elapsed  = {1'b0, tick_whole_ms_q} + {8'd0, us_carry};

		pat_sum  = {1'b0, pattern_accum_q} + {3'b000, elapsed};
		pat_sat  = (pat_sum > swls_pkg::ACCUM_MAX) ? swls_pkg::ACCUM_MAX : pat_sum;
		pat_step = pat_sat >= {2'b00, period_d};
		pat_d    = pat_step ? (pat_sat[10:0] - {1'b0, period_d}) : pat_sat[10:0];

		empt_d  = emptying_q;
		left_d  = left_nibble_q;
		right_d = right_nibble_q;
		if (pat_step) begin
			if (left_nibble_q == swls_pkg::NIBBLE_FULL
				&& right_nibble_q == swls_pkg::NIBBLE_FULL) begin
				empt_d = 1'b1;
			end else if (left_nibble_q == swls_pkg::NIBBLE_EMPTY
				&& right_nibble_q == swls_pkg::NIBBLE_EMPTY) begin
				empt_d = 1'b0;
			end
			if (!empt_d) begin
				right_d = {right_nibble_q[2:0], 1'b1};
				left_d  = {1'b1, left_nibble_q[3:1]};
			end else begin
				left_d  = {left_nibble_q[2:0], 1'b0};
				right_d = {1'b0, right_nibble_q[3:1]};
			end
		end

		ms_sum   = {1'b0, ms_count_q} + {2'b00, elapsed};
		ms_wrap  = ms_sum >= swls_pkg::MS_PER_SEC;
		sec_inc  = {1'b0, sec_count_q} + 7'd1;
		sec_wrap = sec_inc >= swls_pkg::SEC_PER_MIN;
		min_inc  = {1'b0, min_count_q} + 7'd1;
		min_wrap = min_inc >= swls_pkg::MIN_PER_HOUR;

		ms_d   = ms_count_q;
		sec_d  = sec_count_q;
		min_d  = min_count_q;
		hour_d = hour_count_q;
		if (mode_d == swls_pkg::MODE_CLEAR) begin
			ms_d   = 10'd0;
			sec_d  = 6'd0;
			min_d  = 6'd0;
			hour_d = 8'd0;
		end else if (mode_d == swls_pkg::MODE_RUN) begin
			if (!ms_wrap) begin
				ms_d = ms_sum[9:0];
			end else begin
				ms_d = 10'd0;
				if (!sec_wrap) begin
					sec_d = sec_inc[5:0];
				end else begin
					sec_d = 6'd0;
					if (!min_wrap) begin
						min_d = min_inc[5:0];
					end else begin
						min_d  = 6'd0;
						hour_d = hour_count_q + 8'd1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_whole_ms_q  <= swls_pkg::TICK_WHOLE_MS_RST;
			tick_extra_us_q  <= swls_pkg::TICK_EXTRA_US_RST;
			speed_step_q     <= swls_pkg::SPEED_STEP_RST;
			period_floor_q   <= swls_pkg::PERIOD_FLOOR_RST;
			period_ceiling_q <= swls_pkg::PERIOD_CEILING_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				swls_pkg::CFG_TICK_WHOLE_MS:  tick_whole_ms_q  <= cfg_data[7:0];
				swls_pkg::CFG_TICK_EXTRA_US:  tick_extra_us_q  <= cfg_data;
				swls_pkg::CFG_SPEED_STEP:     speed_step_q     <= cfg_data[7:0];
				swls_pkg::CFG_PERIOD_FLOOR:   period_floor_q   <= cfg_data;
				swls_pkg::CFG_PERIOD_CEILING: period_ceiling_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			us_accum_q      <= '0;
			pattern_accum_q <= '0;
			scan_period_q   <= swls_pkg::SCAN_PERIOD_RST;
			left_nibble_q   <= swls_pkg::LEFT_NIBBLE_RST;
			right_nibble_q  <= swls_pkg::RIGHT_NIBBLE_RST;
			emptying_q      <= 1'b0;
			mode_q          <= swls_pkg::MODE_RUN;
			ms_count_q      <= '0;
			sec_count_q     <= '0;
			min_count_q     <= '0;
			hour_count_q    <= '0;
		end else if (accept) begin
			us_accum_q      <= us_d;
			pattern_accum_q <= pat_d;
			scan_period_q   <= period_d;
			left_nibble_q   <= left_d;
			right_nibble_q  <= right_d;
			emptying_q      <= empt_d;
			mode_q          <= mode_d;
			ms_count_q      <= ms_d;
			sec_count_q     <= sec_d;
			min_count_q     <= min_d;
			hour_count_q    <= hour_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (accept) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.led_pattern <= {left_d, right_d};
			result_q.millis      <= ms_d;
			result_q.seconds     <= sec_d;
			result_q.minutes     <= min_d;
			result_q.hours       <= hour_d;
			result_q.run_mode    <= mode_d;
		end
	end

endmodule
